### hw/rtl/ffpa_pkg.sv
`default_nettype none

package ffpa_pkg;

    localparam int FIELD_W = 10;

    // request function codes
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_INIT  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NO_FIT     = 2'd1;
    localparam logic [1:0] STAT_BAD_HANDLE = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] req_bytes;
        logic [FIELD_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] payload_offset;
        logic [FIELD_W-1:0] used_bytes;
        logic [FIELD_W-1:0] free_bytes;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_EVAL_FIT,
        OP_EVAL_MATCH,
        OP_SPLIT,
        OP_TAKE,
        OP_MARK,
        OP_MERGE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     sel;
        logic     left_sel;
        logic     above;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUOT,
        ST_NEED,
        ST_EVAL,
        ST_PICK,
        ST_APPLY,
        ST_MERGE_PREV,
        ST_INIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/first_fit_pool_allocator_unit.sv
// a request steps through states: allocate QUOT, NEED, EVAL, PICK, APPLY, DONE (PICK goes to
// DONE when nothing fits); free EVAL, PICK, APPLY, DONE, with MERGE_PREV before DONE when the
// freed segment merges with both neighbors and PICK to DONE when the handle matches no segment;
// reinit INIT, DONE; a request rejected on its fields or with an unknown function goes to DONE;
// one request in flight; the next is taken in the cycle after its result is registered (a
// stalled earlier result holds it); reset (rst_n low, asynchronous) leaves one free segment
`default_nettype none

module first_fit_pool_allocator_unit #(
    parameter int POOL_BYTES   = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 16,
    parameter int MAX_SEGMENTS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ffpa_pkg::req_t req_data,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ffpa_pkg::rsp_t      rsp_data
);

    import ffpa_pkg::*;

    localparam int W       = ($clog2(POOL_BYTES + 1) > 11) ? $clog2(POOL_BYTES + 1) : 11;
    localparam int CW      = $clog2(MAX_SEGMENTS + 1);
    localparam int PAYLOAD = POOL_BYTES - HEADER_BYTES;
    // round-up by reciprocal multiply, exact for numerators below 2**N_W
    localparam int N_W     = FIELD_W + 1;
    localparam int SH      = N_W + $clog2(ALIGN_BYTES);
    localparam int RECIP   = ((1 << SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PW      = N_W + SH + 1;

    localparam logic [W-1:0] HDR_W        = W'(HEADER_BYTES);
    localparam logic [W:0]   SPLIT_MARGIN = (W + 1)'(HEADER_BYTES + 1);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [W-1:0]         used_reg, used_next;
    logic [W-1:0]         avail_reg, avail_next;
    logic [MAX_SEGMENTS-1:0] tgt_reg, tgt_next;
    logic [1:0]           stat_reg, stat_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [1:0]           func_reg, func_next;
    logic [FIELD_W-1:0]   req_bytes_reg, req_bytes_next;
    logic [FIELD_W-1:0]   handle_reg, handle_next;
    logic [N_W-1:0]       quot_reg, quot_next;
    logic [W-1:0]         need_reg, need_next;
    logic [W-1:0]         off_reg, off_next;
    rsp_t                 rsp_reg, rsp_next;

    cell_op_t             cell_op;
    logic                 shift_prev;
    logic [W-1:0]         key;
    logic [MAX_SEGMENTS-1:0] tgt_use;
    logic [MAX_SEGMENTS-1:0] above;

    logic [W-1:0]         start_arr [MAX_SEGMENTS];
    logic [W-1:0]         bytes_arr [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] free_vec;
    logic [MAX_SEGMENTS-1:0] valid_vec;
    logic [MAX_SEGMENTS-1:0] hit_vec;

    logic [W-1:0]         sel_start;
    logic [W-1:0]         sel_bytes;
    logic                 sel_free;
    logic                 prev_free;
    logic                 next_free;
    logic                 split_ok;

    logic [N_W-1:0]       round_num;
    logic [PW-1:0]        quot_prod;
    logic [2*N_W-1:0]     need_prod;

    assign round_num = N_W'(req_bytes_reg) + N_W'(ALIGN_BYTES - 1);
    assign quot_prod = PW'(round_num) * PW'(RECIP);
    assign need_prod = (2 * N_W)'(quot_reg) * (2 * N_W)'(ALIGN_BYTES);

    assign key     = (func_reg == FUNC_ALLOC) ? need_reg : W'(handle_reg);
    assign tgt_use = shift_prev ? (tgt_reg >> 1) : tgt_reg;
    assign above   = ~(tgt_use | (tgt_use - MAX_SEGMENTS'(1)));

    // one-hot read of the target segment
    always_comb
    begin
        sel_start = '0;
        sel_bytes = '0;
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            sel_start = sel_start | (start_arr[k] & {W{tgt_reg[k]}});
            sel_bytes = sel_bytes | (bytes_arr[k] & {W{tgt_reg[k]}});
        end
    end

    assign sel_free  = |(free_vec & tgt_reg);
    assign prev_free = |(free_vec & (tgt_reg >> 1));
    assign next_free = |(free_vec & (tgt_reg << 1));
    assign split_ok  = ({1'b0, sel_bytes} >= ({1'b0, need_reg} + SPLIT_MARGIN)) &&
                       (count_reg < CW'(MAX_SEGMENTS));

    for (genvar k = 0; k < MAX_SEGMENTS; k++)
    begin : g_cell
        cell_ctl_t    ctl;
        logic [W-1:0] l_start, l_bytes, r_start, r_bytes;
        logic         l_free, l_valid, l_sel, r_free, r_valid;

        if (k == 0)
        begin : g_left_edge
            assign l_start = '0;
            assign l_bytes = '0;
            assign l_free  = 1'b0;
            assign l_valid = 1'b0;
            assign l_sel   = 1'b0;
        end
        else
        begin : g_left
            assign l_start = start_arr[k-1];
            assign l_bytes = bytes_arr[k-1];
            assign l_free  = free_vec[k-1];
            assign l_valid = valid_vec[k-1];
            assign l_sel   = tgt_use[k-1];
        end

        if (k == MAX_SEGMENTS - 1)
        begin : g_right_edge
            assign r_start = '0;
            assign r_bytes = '0;
            assign r_free  = 1'b0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_right
            assign r_start = start_arr[k+1];
            assign r_bytes = bytes_arr[k+1];
            assign r_free  = free_vec[k+1];
            assign r_valid = valid_vec[k+1];
        end

        assign ctl = '{op: cell_op, sel: tgt_use[k], left_sel: l_sel, above: above[k]};

        ffpa_cell #(
            .W          (W),
            .HDR        (HEADER_BYTES),
            .INIT_BYTES (PAYLOAD),
            .FIRST      (k == 0)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (key),
            .left_start  (l_start),
            .left_bytes  (l_bytes),
            .left_free   (l_free),
            .left_valid  (l_valid),
            .right_start (r_start),
            .right_bytes (r_bytes),
            .right_free  (r_free),
            .right_valid (r_valid),
            .seg_start   (start_arr[k]),
            .seg_bytes   (bytes_arr[k]),
            .seg_free    (free_vec[k]),
            .seg_valid   (valid_vec[k]),
            .hit         (hit_vec[k])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        avail_next     = avail_reg;
        tgt_next       = tgt_reg;
        stat_next      = stat_reg;
        off_next       = off_reg;
        func_next      = func_reg;
        req_bytes_next = req_bytes_reg;
        handle_next    = handle_reg;
        quot_next      = quot_reg;
        need_next      = need_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        rsp_next       = rsp_reg;
        cell_op        = OP_HOLD;
        shift_prev     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next      = req_data.func;
                    req_bytes_next = req_data.req_bytes;
                    handle_next    = req_data.handle;
                    stat_next      = STAT_OK;
                    off_next       = '0;
                    unique case (req_data.func)
                        FUNC_ALLOC:
                        begin
                            if ((req_data.req_bytes == '0) ||
                                (W'(req_data.req_bytes) > W'(PAYLOAD)))
                            begin
                                stat_next  = STAT_NO_FIT;
                                state_next = ST_DONE;
                            end
                            else
                                state_next = ST_QUOT;
                        end
                        FUNC_FREE:
                        begin
                            if (W'(req_data.handle) >= W'(POOL_BYTES))
                            begin
                                stat_next  = STAT_BAD_HANDLE;
                                state_next = ST_DONE;
                            end
                            else
                                state_next = ST_EVAL;
                        end
                        FUNC_INIT:
                            state_next = ST_INIT;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_QUOT:
            begin
                quot_next  = N_W'(quot_prod >> SH);
                state_next = ST_NEED;
            end
            ST_NEED:
            begin
                need_next  = W'(need_prod);
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cell_op    = (func_reg == FUNC_ALLOC) ? OP_EVAL_FIT : OP_EVAL_MATCH;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                // lowest set bit is the first fit in address order
                tgt_next = hit_vec & (~hit_vec + MAX_SEGMENTS'(1));
                if (hit_vec == '0)
                begin
                    stat_next  = (func_reg == FUNC_ALLOC) ? STAT_NO_FIT : STAT_BAD_HANDLE;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_DONE;
                if (func_reg == FUNC_ALLOC)
                begin
                    off_next = sel_start + HDR_W;
                    if (split_ok)
                    begin
                        cell_op    = OP_SPLIT;
                        count_next = count_reg + CW'(1);
                        used_next  = used_reg + need_reg;
                        avail_next = avail_reg - need_reg - HDR_W;
                    end
                    else
                    begin
                        cell_op    = OP_TAKE;
                        used_next  = used_reg + sel_bytes;
                        avail_next = avail_reg - sel_bytes;
                    end
                end
                else if (!sel_free)
                begin
                    used_next = used_reg - sel_bytes;
                    if (next_free || prev_free)
                    begin
                        // merge toward the later neighbor first if it is free
                        cell_op    = OP_MERGE;
                        shift_prev = !next_free;
                        count_next = count_reg - CW'(1);
                        avail_next = avail_reg + sel_bytes + HDR_W;
                        if (next_free && prev_free)
                            state_next = ST_MERGE_PREV;
                    end
                    else
                    begin
                        cell_op    = OP_MARK;
                        avail_next = avail_reg + sel_bytes;
                    end
                end
            end
            ST_MERGE_PREV:
            begin
                cell_op    = OP_MERGE;
                shift_prev = 1'b1;
                count_next = count_reg - CW'(1);
                avail_next = avail_reg + HDR_W;
                state_next = ST_DONE;
            end
            ST_INIT:
            begin
                cell_op    = OP_INIT;
                count_next = CW'(1);
                used_next  = '0;
                avail_next = W'(PAYLOAD);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status:         stat_reg,
                                       payload_offset: off_reg[FIELD_W-1:0],
                                       used_bytes:     used_reg[FIELD_W-1:0],
                                       free_bytes:     avail_reg[FIELD_W-1:0]};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CW'(1);
            used_reg      <= '0;
            avail_reg     <= W'(PAYLOAD);
            tgt_reg       <= '0;
            stat_reg      <= STAT_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            avail_reg     <= avail_next;
            tgt_reg       <= tgt_next;
            stat_reg      <= stat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        req_bytes_reg <= req_bytes_next;
        handle_reg    <= handle_next;
        quot_reg      <= quot_next;
        need_reg      <= need_next;
        off_reg       <= off_next;
        rsp_reg       <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // target of a pick is a single segment at most
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tgt_reg))
        else $error("segment target is not one-hot");

    // live cells agree with the segment count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("segment count disagrees with live cells");

    // payload plus headers always cover the whole pool between requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
        (int'(used_reg) + int'(avail_reg) + HEADER_BYTES * int'(count_reg) == POOL_BYTES))
        else $error("byte totals do not cover the pool");

    // coalescing leaves no two neighboring free segments
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((free_vec & (free_vec >> 1)) == '0))
        else $error("adjacent free segments left unmerged");

endmodule

`default_nettype wire

### hw/rtl/ffpa_cell.sv
`default_nettype none

module ffpa_cell #(
    parameter int W          = 11,
    parameter int HDR        = 24,
    parameter int INIT_BYTES = 1000,
    parameter bit FIRST      = 1'b0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ffpa_pkg::cell_ctl_t  ctl,
    input  wire logic [W-1:0]         key,
    input  wire logic [W-1:0]         left_start,
    input  wire logic [W-1:0]         left_bytes,
    input  wire logic                 left_free,
    input  wire logic                 left_valid,
    input  wire logic [W-1:0]         right_start,
    input  wire logic [W-1:0]         right_bytes,
    input  wire logic                 right_free,
    input  wire logic                 right_valid,
    output logic [W-1:0]              seg_start,
    output logic [W-1:0]              seg_bytes,
    output logic                      seg_free,
    output logic                      seg_valid,
    output logic                      hit
);

    import ffpa_pkg::*;

    localparam logic [W-1:0] HDR_W  = W'(HDR);
    localparam logic [W-1:0] INIT_W = W'(INIT_BYTES);

    logic [W-1:0] start_reg, start_next;
    logic [W-1:0] bytes_reg, bytes_next;
    logic         free_reg, free_next;
    logic         valid_reg, valid_next;
    logic         hit_reg, hit_next;

    always_comb
    begin
        start_next = start_reg;
        bytes_next = bytes_reg;
        free_next  = free_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
            end
            OP_INIT:
            begin
                start_next = '0;
                bytes_next = FIRST ? INIT_W : '0;
                free_next  = FIRST;
                valid_next = FIRST;
            end
            OP_EVAL_FIT:
                hit_next = valid_reg & free_reg & (bytes_reg >= key);
            OP_EVAL_MATCH:
                hit_next = valid_reg & ((start_reg + HDR_W) == key);
            OP_SPLIT:
            begin
                if (ctl.sel)
                begin
                    bytes_next = key;
                    free_next  = 1'b0;
                end
                else if (ctl.left_sel)
                begin
                    // remainder of the segment to the left becomes a new free segment
                    start_next = left_start + HDR_W + key;
                    bytes_next = left_bytes - key - HDR_W;
                    free_next  = 1'b1;
                    valid_next = 1'b1;
                end
                else if (ctl.above)
                begin
                    start_next = left_start;
                    bytes_next = left_bytes;
                    free_next  = left_free;
                    valid_next = left_valid;
                end
            end
            OP_TAKE:
            begin
                if (ctl.sel)
                    free_next = 1'b0;
            end
            OP_MARK:
            begin
                if (ctl.sel)
                    free_next = 1'b1;
            end
            OP_MERGE:
            begin
                if (ctl.sel)
                begin
                    // absorb the right neighbor, header included
                    bytes_next = bytes_reg + right_bytes + HDR_W;
                    free_next  = 1'b1;
                end
                else if (ctl.above)
                begin
                    start_next = right_start;
                    bytes_next = right_bytes;
                    free_next  = right_free;
                    valid_next = right_valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            bytes_reg <= FIRST ? INIT_W : '0;
            free_reg  <= FIRST;
            valid_reg <= FIRST;
            hit_reg   <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            bytes_reg <= bytes_next;
            free_reg  <= free_next;
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign seg_start = start_reg;
    assign seg_bytes = bytes_reg;
    assign seg_free  = free_reg;
    assign seg_valid = valid_reg;
    assign hit       = hit_reg;

endmodule

`default_nettype wire
